FILE: rtl/sorted_range_set_insert_merge_assert.svh
// Assertion macros for the sorted range set checker.
`ifndef SORTED_RANGE_SET_INSERT_MERGE_ASSERT_SVH
`define SORTED_RANGE_SET_INSERT_MERGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRSIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted range set check failed");

// Next-cycle implication, checked out of reset.
`define SRSIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted range set check failed");

`endif

FILE: rtl/srsim_pkg.sv
// Shared types and constants for the sorted range set.
`default_nettype none
package srsim_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int CP_W = 21;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_RD_WAIT, S_F_RD, S_F_EV, S_P_RD, S_P_EV,
        S_CHK, S_MV_RD, S_MV_WR, S_WRM, S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       rd_idx;
        logic       rd_ptr;
        logic       ptr_inc;
        logic       set_first;
        logic       merge;
        logic       mv_setup;
        logic       mv_step;
        logic       wr_merged;
        logic       commit;
        logic       st_en;
        logic [1:0] st_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ptr_lt;
        logic       below;
        logic       touch;
        logic       bad;
        logic       idx_ok;
        logic       full;
        logic       left_zero;
    } stat_t;
endpackage
`default_nettype wire

FILE: rtl/sorted_range_set_insert_merge.sv
// Sorted range set top level: stream ports, controller and datapath.
// A clear, a read and a bad-range insert finish without a scan; any other insert
// scans the table entry by entry and, unless the table would overflow, moves the
// tail one entry at a time before writing the merged range.
// One request at a time; a finished result may wait while the next is taken.
// aresetn (synchronous) empties the table; entry contents are not cleared.
`default_nettype none
module sorted_range_set_insert_merge #(
    parameter int TABLE_DEPTH = srsim_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // op[1:0], range_low, range_high, read_index, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata   // entry_count[6:0], entry_low, entry_high, status, pad
);
    import srsim_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [6:0]  entry_count;
    logic [20:0] entry_low, entry_high;
    logic [1:0]  status;

    srsim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    srsim_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .op         (s_tdata[1:0]),
        .range_low  (s_tdata[22:2]),
        .range_high (s_tdata[43:23]),
        .read_index (s_tdata[49:44]),
        .entry_count(entry_count),
        .entry_low  (entry_low),
        .entry_high (entry_high),
        .status     (status)
    );

    assign m_tdata = {5'd0, status, entry_high, entry_low, entry_count};
endmodule
`default_nettype wire

FILE: rtl/srsim_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module srsim_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/srsim_ctrl.sv
// Control state machine for the sorted range set.
`default_nettype none
module srsim_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire srsim_pkg::stat_t stat,
    output srsim_pkg::cmd_t      cmd
);
    import srsim_pkg::*;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.st_en  = 1'b1;
                state_next = S_DONE;
                case (stat.op)
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    OP_READ: begin
                        if (stat.idx_ok) begin
                            cmd.rd_idx = 1'b1;
                            state_next = S_RD_WAIT;
                        end else begin
                            cmd.st_code = ST_INDEX;
                        end
                    end
                    OP_INSERT: begin
                        if (stat.bad) begin
                            cmd.st_code = ST_BAD;
                        end else begin
                            state_next = S_F_RD;
                        end
                    end
                    default: begin
                        cmd.st_code = ST_OK;
                    end
                endcase
            end
            S_RD_WAIT: begin
                state_next = S_DONE;
            end
            S_F_RD: begin
                if (stat.ptr_lt) begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_F_EV;
                end else begin
                    cmd.set_first = 1'b1;
                    state_next    = S_P_RD;
                end
            end
            S_F_EV: begin
                if (stat.below) begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_F_RD;
                end else begin
                    cmd.set_first = 1'b1;
                    state_next    = S_P_EV;
                end
            end
            S_P_RD: begin
                if (stat.ptr_lt) begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_P_EV;
                end else begin
                    state_next = S_CHK;
                end
            end
            S_P_EV: begin
                if (stat.touch) begin
                    cmd.merge   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_P_RD;
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (stat.full) begin
                    cmd.st_en   = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    cmd.mv_setup = 1'b1;
                    state_next   = S_MV_RD;
                end
            end
            S_MV_RD: begin
                if (!stat.left_zero) begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_MV_WR;
                end else begin
                    state_next = S_WRM;
                end
            end
            S_MV_WR: begin
                cmd.mv_step = 1'b1;
                state_next  = S_MV_RD;
            end
            S_WRM: begin
                cmd.wr_merged = 1'b1;
                cmd.commit    = 1'b1;
                cmd.st_en     = 1'b1;
                cmd.st_code   = ST_OK;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        valid_next = cmd.out_load | (valid_reg & ~m_tready);
    end

    assign m_tvalid = valid_reg;
endmodule
`default_nettype wire

FILE: rtl/srsim_dp.sv
// Datapath: request registers, scan pointers, merge bounds and result register.
`default_nettype none
module srsim_dp #(
    parameter int TABLE_DEPTH = srsim_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire srsim_pkg::cmd_t cmd,
    output srsim_pkg::stat_t     stat,
    input  wire logic [1:0]      op,
    input  wire logic [20:0]     range_low,
    input  wire logic [20:0]     range_high,
    input  wire logic [5:0]      read_index,
    output logic      [6:0]      entry_count,
    output logic      [20:0]     entry_low,
    output logic      [20:0]     entry_high,
    output logic      [1:0]      status
);
    import srsim_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (CW > 6) ? CW : 6;

    logic [1:0]      op_reg;
    logic [20:0]     lo_reg, hi_reg, mlo_reg, mhi_reg;
    logic [5:0]      idx_reg;
    logic [CW-1:0]   count_reg, first_reg, ptr_reg, gap_reg, left_reg;
    logic [1:0]      st_reg;
    logic [6:0]      ocount_reg;
    logic [20:0]     olo_reg, ohi_reg;
    logic [1:0]      ost_reg;
    logic [2*CP_W-1:0] rdata, wdata;
    logic [20:0]     r_lo, r_hi;
    logic [CW-1:0]   dest;
    logic [CW:0]     new_count;
    logic            we, re, rd_hit;
    logic [AW-1:0]   waddr, raddr;

    assign r_lo      = rdata[20:0];
    assign r_hi      = rdata[41:21];
    assign dest      = ptr_reg + CW'(1) - gap_reg;
    assign new_count = {1'b0, count_reg} - {1'b0, ptr_reg - first_reg} + (CW+1)'(1);

    always_comb begin
        stat.op        = op_reg;
        stat.ptr_lt    = ptr_reg < count_reg;
        stat.below     = ({1'b0, r_hi} + 22'd1) < {1'b0, lo_reg};
        stat.touch     = {1'b0, r_lo} <= ({1'b0, hi_reg} + 22'd1);
        stat.bad       = lo_reg > hi_reg;
        stat.idx_ok    = XW'(idx_reg) < XW'(count_reg);
        stat.full      = new_count > (CW+1)'(TABLE_DEPTH);
        stat.left_zero = left_reg == '0;
    end

    assign re    = cmd.rd_idx | cmd.rd_ptr;
    assign raddr = cmd.rd_idx ? AW'(idx_reg) : ptr_reg[AW-1:0];
    assign we    = cmd.mv_step | cmd.wr_merged;
    assign waddr = cmd.wr_merged ? first_reg[AW-1:0] : dest[AW-1:0];
    assign wdata = cmd.wr_merged ? {mhi_reg, mlo_reg} : rdata;

    srsim_ram #(
        .WIDTH(2 * CP_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_reg - gap_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= op;
            lo_reg  <= range_low;
            hi_reg  <= range_high;
            idx_reg <= read_index;
            mlo_reg <= range_low;
            mhi_reg <= range_high;
            ptr_reg <= '0;
        end
        if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + CW'(1);
        end
        if (cmd.set_first) begin
            first_reg <= ptr_reg;
        end
        if (cmd.merge) begin
            if (r_lo < mlo_reg) begin
                mlo_reg <= r_lo;
            end
            if (r_hi > mhi_reg) begin
                mhi_reg <= r_hi;
            end
        end
        if (cmd.mv_setup) begin
            gap_reg  <= ptr_reg - first_reg;
            left_reg <= count_reg - ptr_reg;
            // no entry absorbed: tail moves up, copied from the top down
            if (ptr_reg == first_reg) begin
                ptr_reg <= count_reg - CW'(1);
            end
        end
        if (cmd.mv_step) begin
            left_reg <= left_reg - CW'(1);
            ptr_reg  <= (gap_reg == '0) ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
        end
        if (cmd.st_en) begin
            st_reg <= cmd.st_code;
        end
        if (cmd.out_load) begin
            ocount_reg <= 7'(count_reg);
            olo_reg    <= rd_hit ? r_lo : '0;
            ohi_reg    <= rd_hit ? r_hi : '0;
            ost_reg    <= st_reg;
        end
    end

    assign rd_hit      = (op_reg == OP_READ) && (st_reg == ST_OK);
    assign entry_count = ocount_reg;
    assign entry_low   = olo_reg;
    assign entry_high  = ohi_reg;
    assign status      = ost_reg;
endmodule
`default_nettype wire

FILE: rtl/srsim_checker.sv
// Port-level checks for the sorted range set, bound to the top level.
`default_nettype none
`include "sorted_range_set_insert_merge_assert.svh"
module srsim_checker #(
    parameter int TABLE_DEPTH = srsim_pkg::DEFAULT_TABLE_DEPTH
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    import srsim_pkg::*;

    `SRSIM_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SRSIM_ASSERT_IMP(a_order, aclk, aresetn, m_tvalid, m_tdata[27:7] <= m_tdata[48:28])
    `SRSIM_ASSERT_IMP(a_full, aclk, aresetn, m_tvalid && m_tdata[50:49] == ST_FULL, m_tdata[6:0] == 7'(TABLE_DEPTH))
    `SRSIM_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && m_tdata[50:49] != ST_OK, m_tdata[48:7] == 42'd0)
endmodule

bind sorted_range_set_insert_merge srsim_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_srsim_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire

FILE: bench/sorted_range_set_insert_merge_test.sv
// Testbench for the sorted range set: random and directed requests, checked by a scoreboard.
`timescale 1ns / 1ps
module sorted_range_set_insert_merge_test;
    import srsim_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] hi;
        logic [20:0] lo;
        logic [6:0]  count;
    } range_result_t;

    class range_set_board;
        logic [20:0] lows[DEPTH];
        logic [20:0] highs[DEPTH];
        int unsigned count;
        range_result_t pending[$];
        int errors;

        function void reset_table();
            count = 0;
            errors = 0;
            pending.delete();
        endfunction

        function logic [1:0] merge_in(logic [20:0] lo, logic [20:0] hi);
            int unsigned first, past, new_count;
            logic [20:0] mlo, mhi;
            if (lo > hi) return ST_BAD;
            first = 0;
            mlo = lo;
            mhi = hi;
            while (first < count && {1'b0, highs[first]} + 22'd1 < {1'b0, lo}) first++;
            past = first;
            while (past < count && {1'b0, lows[past]} <= {1'b0, hi} + 22'd1) begin
                if (lows[past] < mlo) mlo = lows[past];
                if (highs[past] > mhi) mhi = highs[past];
                past++;
            end
            new_count = count - (past - first) + 1;
            if (new_count > DEPTH) return ST_FULL;
            if (past > first + 1) begin
                for (int i = 0; i < count - past; i++) begin
                    lows[first + 1 + i] = lows[past + i];
                    highs[first + 1 + i] = highs[past + i];
                end
            end else if (past == first) begin
                for (int i = count; i > first; i--) begin
                    lows[i] = lows[i - 1];
                    highs[i] = highs[i - 1];
                end
            end
            lows[first] = mlo[20:0];
            highs[first] = mhi[20:0];
            count = new_count;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] op, logic [20:0] lo, logic [20:0] hi,
                                   logic [5:0] idx);
            range_result_t r;
            r = '0;
            if (op == OP_CLEAR) count = 0;
            else if (op == OP_INSERT) r.status = merge_in(lo, hi);
            else if (op == OP_READ) begin
                if (idx < count) begin
                    r.lo = lows[idx];
                    r.hi = highs[idx];
                end else r.status = ST_INDEX;
            end
            r.count = count[6:0];
            pending = {pending, r};
        endfunction

        function void check_result(range_result_t got);
            range_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.count !== want.count) begin
                $display("%0t: count exp %0d got %0d", $realtime, want.count, got.count);
                errors++;
            end
            if (got.lo !== want.lo) begin
                $display("%0t: low exp %h got %h", $realtime, want.lo, got.lo);
                errors++;
            end
            if (got.hi !== want.hi) begin
                $display("%0t: high exp %h got %h", $realtime, want.hi, got.hi);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [55:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [55:0] m_tdata;

    range_set_board board = new();
    int idle_cycles = 0;
    bit stalls_on = 1;

    sorted_range_set_insert_merge dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata[50:0]);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("** sorted_range_set_insert_merge: FAILED **");
            $finish;
        end
    end

    // receiver: stalls at random, some stretches with none
    always @(posedge aclk) begin
        if (!stalls_on) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(logic [1:0] op, logic [20:0] lo, logic [20:0] hi, logic [5:0] idx);
        s_tvalid <= 1;
        s_tdata <= {7'd0, idx, hi, lo, op};
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, lo, hi, idx);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [20:0] rand_cp(int span);
        if ($urandom_range(0, 19) == 0) return 21'($urandom());
        return 21'($urandom_range(0, span));
    endfunction

    initial begin
        logic [20:0] a, b;
        int burst, span, kind;
        board.reset_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(OP_READ, 0, 0, 0);
        send(OP_INSERT, 21'd0, 21'd0, 0);
        send(OP_INSERT, 21'h1FFFFF, 21'h1FFFFF, 0);
        send(OP_INSERT, 21'h10FFFF, 21'h10FFFE, 0);
        send(OP_INSERT, 21'd10, 21'd20, 0);
        send(OP_INSERT, 21'd22, 21'd30, 0);
        send(OP_INSERT, 21'd21, 21'd21, 0);
        send(OP_INSERT, 21'd1, 21'd9, 0);
        send(OP_READ, 0, 0, 0);
        send(OP_READ, 0, 0, 1);
        send(OP_READ, 0, 0, 6'd63);
        send(OP_NONE, 21'h1FFFFF, 21'h1FFFFF, 6'h3F);
        send(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < DEPTH; i++) send(OP_INSERT, 21'(4 * i + 100), 21'(4 * i + 101), 0);
        send(OP_INSERT, 21'd5000, 21'd5001, 0);
        send(OP_INSERT, 21'd102, 21'd102, 0);
        send(OP_READ, 0, 0, 6'd63);
        send(OP_INSERT, 21'd0, 21'h1FFFFF, 0);
        send(OP_READ, 0, 0, 0);
        drain();
        repeat (200) @(posedge aclk);

        for (int n = 0; n < 1900; ) begin
            burst = $urandom_range(1, 12);
            span = ($urandom_range(0, 2) == 0) ? 300 : 4000;
            stalls_on = ($urandom_range(0, 4) != 0);
            for (int k = 0; k < burst; k++, n++) begin
                kind = $urandom_range(0, 99);
                a = rand_cp(span);
                b = a + 21'($urandom_range(0, 40));
                if (kind < 2)
                    send(OP_CLEAR, 21'($urandom()), 21'($urandom()), 6'($urandom()));
                else if (kind < 60) send(OP_INSERT, a, b, 6'($urandom()));
                else if (kind < 66) send(OP_INSERT, b + 21'd1, a, 6'($urandom()));
                else if (kind < 95)
                    send(OP_READ, 21'($urandom()), 21'($urandom()),
                         6'($urandom_range(0, board.count < 64 ? board.count : 63)));
                else if (kind < 98)
                    send(OP_READ, 21'($urandom()), 21'($urandom()), 6'($urandom()));
                else send(OP_NONE, 21'($urandom()), 21'($urandom()), 6'($urandom()));
            end
            if ($urandom_range(0, 29) == 0) drain();
            else gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 150));
        end

        drain();
        repeat (300) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** sorted_range_set_insert_merge: PASSED **");
        else
            $display("** sorted_range_set_insert_merge: FAILED **");
        $finish;
    end
endmodule
